[sv/agf_pkg.sv]
package agf_pkg;

   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int GAIN_FRAC_BITS_DEF = 22;

   // Log2 values carry this many fraction bits.
   localparam int LOG_FRAC = 16;

   localparam int TARGET_W   = 24;
   localparam int STEP_W     = 25;
   localparam int RAMP_W     = 24;
   localparam int EXP_STEP_W = 20;
   localparam int MODE_W     = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;

   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINEAR_STEP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_SAMPLES  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_STEP_LOG2 = 3'd4;

   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EXP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HYBRID = 2'd2;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 24'd4194304;

   typedef struct packed {
      logic [MODE_W-1:0]        fade_mode;
      logic [TARGET_W-1:0]      target_gain;
      logic signed [STEP_W-1:0] linear_step;
      logic [RAMP_W-1:0]        ramp_samples;
      logic [EXP_STEP_W-1:0]    exp_step_log2;
   } cfg_type;

endpackage

[sv/agf_gain.sv]
module agf_gain #(
   parameter int GAIN_FRAC_BITS = agf_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  agf_pkg::cfg_type            cfg,
   input  logic                        ramp_load,
   input  logic [agf_pkg::RAMP_W-1:0]  ramp_load_value,
   input  logic                        advance,
   output logic [GAIN_FRAC_BITS+1:0]   gain_new
);

   localparam int GB   = GAIN_FRAC_BITS + 2;
   localparam int TW   = (GB > agf_pkg::TARGET_W) ? GB : agf_pkg::TARGET_W;
   localparam int NW   = $clog2(TW);
   localparam int IPW  = $clog2(TW) + 1;
   localparam int LW   = IPW + agf_pkg::LOG_FRAC;
   localparam int EW   = LW + 6;
   localparam int SW   = EW - agf_pkg::LOG_FRAC + 1;
   localparam int MW   = agf_pkg::LOG_FRAC + 1;
   localparam int MAX_LSH = GB - MW;
   localparam int SHW  = $clog2(MAX_LSH + 1);
   localparam int SUMW = ((GB > agf_pkg::STEP_W) ? GB : agf_pkg::STEP_W) + 2;

   localparam logic [GB-1:0] GAIN_MAX   = {GB{1'b1}};
   localparam logic [GB-1:0] GAIN_FLOOR = GB'(4);
   localparam logic [GB-1:0] HYB_THRESH = GB'((64'd1 << GAIN_FRAC_BITS) / 10);

   logic [GB-1:0]                 gain_ff;
   logic [GB-1:0]                 gain_in;
   logic [agf_pkg::RAMP_W-1:0]    ramp_ff;
   logic [agf_pkg::RAMP_W-1:0]    ramp_in;

   // Mitchell log2: exponent from the leading one, mantissa bits below it as fraction.
   function automatic logic signed [LW-1:0] mlog2(input logic [TW-1:0] u);
      logic [NW-1:0]               n;
      logic [TW-1:0]               norm;
      logic signed [IPW-1:0]       ip;
      n = '0;
      for (int b = 0; b < TW; b++) begin
         if (u[b]) begin
            n = NW'(b);
         end
      end
      norm = u << (NW'(TW - 1) - n);
      ip   = IPW'(n) - IPW'(GAIN_FRAC_BITS);
      return {ip, norm[TW-2 -: agf_pkg::LOG_FRAC]};
   endfunction

   // Mitchell exp2 back to a saturated gain.
   function automatic logic [GB-1:0] mexp2(input logic signed [EW-1:0] l);
      logic signed [EW-agf_pkg::LOG_FRAC-1:0] ipart;
      logic [MW-1:0]                          m;
      logic signed [SW-1:0]                   s;
      logic signed [SW-1:0]                   k;
      logic [GB-1:0]                          r;
      ipart = l[EW-1:agf_pkg::LOG_FRAC];
      m     = {1'b1, l[agf_pkg::LOG_FRAC-1:0]};
      s     = SW'(ipart) + SW'(GAIN_FRAC_BITS - agf_pkg::LOG_FRAC);
      k     = -s;
      if (s > SW'(MAX_LSH)) begin
         r = GAIN_MAX;
      end else if (!s[SW-1]) begin
         r = GB'(m) << s[SHW-1:0];
      end else if (k > SW'(MW - 1)) begin
         r = '0;
      end else begin
         r = GB'(m >> k[$clog2(MW)-1:0]);
      end
      return r;
   endfunction

   function automatic logic [GB-1:0] clamp_target(input logic [TW-1:0] t);
      logic [GB-1:0] r;
      if (t > TW'(GAIN_MAX)) begin
         r = GAIN_MAX;
      end else begin
         r = t[GB-1:0];
      end
      return r;
   endfunction

   logic signed [SUMW-1:0] lin_sum;
   logic [GB-1:0]          lin_gain;
   logic [agf_pkg::RAMP_W-1:0] lin_ramp;
   logic [GB-1:0]          cur_floor;
   logic [TW-1:0]          tgt_floor;
   logic signed [LW-1:0]   lc;
   logic signed [LW-1:0]   lt;
   logic signed [EW-1:0]   diff;
   logic signed [EW-1:0]   mag;
   logic signed [EW-1:0]   st;
   logic [GB-1:0]          exp_gain;

   always_comb begin
      lin_sum = SUMW'($signed({1'b0, gain_ff})) + SUMW'(cfg.linear_step);
      if (ramp_ff != '0) begin
         lin_ramp = ramp_ff - 1'b1;
         if (lin_sum < 0) begin
            lin_gain = '0;
         end else if (lin_sum > $signed({{(SUMW-GB){1'b0}}, GAIN_MAX})) begin
            lin_gain = GAIN_MAX;
         end else begin
            lin_gain = lin_sum[GB-1:0];
         end
      end else begin
         lin_ramp = ramp_ff;
         lin_gain = clamp_target(TW'(cfg.target_gain));
      end
   end

   always_comb begin
      cur_floor = (gain_ff < GAIN_FLOOR) ? GAIN_FLOOR : gain_ff;
      tgt_floor = (cfg.target_gain < agf_pkg::TARGET_W'(4)) ? TW'(4) : TW'(cfg.target_gain);
      lc   = mlog2(TW'(cur_floor));
      lt   = mlog2(tgt_floor);
      diff = EW'(lt) - EW'(lc);
      mag  = diff[EW-1] ? -diff : diff;
      st   = EW'(cfg.exp_step_log2);
      if (mag < st) begin
         exp_gain = clamp_target(tgt_floor);
      end else if (diff > 0) begin
         exp_gain = mexp2(EW'(lc) + st);
      end else begin
         exp_gain = mexp2(EW'(lc) - st);
      end
   end

   always_comb begin
      gain_in = gain_ff;
      ramp_in = ramp_ff;
      case (cfg.fade_mode)
         agf_pkg::MODE_LINEAR: begin
            gain_in = lin_gain;
            ramp_in = lin_ramp;
         end
         agf_pkg::MODE_EXP: begin
            gain_in = exp_gain;
         end
         agf_pkg::MODE_HYBRID: begin
            if (gain_ff < HYB_THRESH) begin
               gain_in = lin_gain;
               ramp_in = lin_ramp;
            end else begin
               gain_in = exp_gain;
            end
         end
         default: begin
            gain_in = gain_ff;
         end
      endcase
   end

   assign gain_new = gain_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         ramp_ff <= '0;
      end else if (ramp_load) begin
         ramp_ff <= ramp_load_value;
      end else if (advance) begin
         gain_ff <= gain_in;
         ramp_ff <= ramp_in;
      end
   end

endmodule

[sv/agf_scale.sv]
module agf_scale #(
   parameter int SAMPLE_BITS    = agf_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = agf_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [SAMPLE_BITS-1:0]    in_sample,
   input  logic [GAIN_FRAC_BITS+1:0] in_gain,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [SAMPLE_BITS-1:0]    out_sample
);

   localparam int GB = GAIN_FRAC_BITS + 2;
   localparam int PW = SAMPLE_BITS + GB + 1;
   localparam int QW = PW - GAIN_FRAC_BITS;

   localparam logic signed [QW-1:0] Q_MAX =
      {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [QW-1:0] Q_MIN =
      {{(QW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic                          a_valid_ff;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic [GB-1:0]                 a_gain_ff;
   logic                          b_valid_ff;
   logic signed [PW-1:0]          b_prod_ff;
   logic signed [PW-1:0]          b_prod_in;
   logic                          c_valid_ff;
   logic [SAMPLE_BITS-1:0]        c_sample_ff;
   logic [SAMPLE_BITS-1:0]        c_sample_in;
   logic signed [QW-1:0]          q;
   logic                          a_ready;
   logic                          b_ready;
   logic                          c_ready;

   // Each stage moves on when it is empty or the stage after it moves.
   assign c_ready = !c_valid_ff || out_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;

   assign b_prod_in = a_sample_ff * $signed({1'b0, a_gain_ff});

   // Arithmetic shift floors toward minus infinity, then saturate.
   always_comb begin
      q = b_prod_ff[PW-1:GAIN_FRAC_BITS];
      if (q > Q_MAX) begin
         c_sample_in = Q_MAX[SAMPLE_BITS-1:0];
      end else if (q < Q_MIN) begin
         c_sample_in = Q_MIN[SAMPLE_BITS-1:0];
      end else begin
         c_sample_in = q[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_sample_ff <= in_sample;
         a_gain_ff   <= in_gain;
      end
      if (b_ready && a_valid_ff) begin
         b_prod_ff <= b_prod_in;
      end
      if (c_ready && b_valid_ff) begin
         c_sample_ff <= c_sample_in;
      end
   end

   assign in_ready   = a_ready;
   assign out_valid  = c_valid_ff;
   assign out_sample = c_sample_ff;

endmodule

[sv/audio_gain_fader_top.sv]
// Audio gain fader: scales a stream of signed samples by a gain that ramps
// toward a programmed target, linearly, exponentially or in a hybrid way.
// Requests arrive on the req_ stream (one sample per request in req_tdata),
// scaled samples leave on the rsp_ stream in the same order, one per request.
// Registers are written through the csr_ port (csr_index selects the register,
// csr_data carries the value); csr_ready is always high. Any write to a known
// register reloads the ramp counter, and writes are expected only while no
// request is in flight.
// The gain is updated in the cycle a request is accepted, so one request can
// be taken every cycle while the output is not stalled. The result shows on
// rsp_tvalid after it passes an input register, a register after the
// sample-by-gain multiplier and the saturating output register.
// When rsp_tready is low, the pipeline keeps taking requests until its three
// stages are full, then holds req_tready low; nothing is dropped.
// Reset clears the gain and ramp counter to zero, loads the register defaults
// (linear mode, unity target) and empties the pipeline.
module audio_gain_fader_top #(
   parameter int SAMPLE_BITS    = agf_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = agf_pkg::GAIN_FRAC_BITS_DEF,
   parameter int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [DATA_W-1:0]                  req_tdata,   // sample_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [DATA_W-1:0]                  rsp_tdata,   // sample_out
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [agf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [agf_pkg::CSR_DATA_W-1:0]     csr_data
);

   agf_pkg::cfg_type             cfg_ff;
   agf_pkg::cfg_type             cfg_in;
   logic                         cfg_hit;
   logic                         req_accept;
   logic [GAIN_FRAC_BITS+1:0]    gain_new;
   logic [SAMPLE_BITS-1:0]       rsp_sample;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      cfg_in  = cfg_ff;
      cfg_hit = 1'b0;
      if (csr_valid) begin
         cfg_hit = 1'b1;
         case (csr_index)
            agf_pkg::CSR_FADE_MODE:
               cfg_in.fade_mode = csr_data[agf_pkg::MODE_W-1:0];
            agf_pkg::CSR_TARGET_GAIN:
               cfg_in.target_gain = csr_data[agf_pkg::TARGET_W-1:0];
            agf_pkg::CSR_LINEAR_STEP:
               cfg_in.linear_step = $signed(csr_data[agf_pkg::STEP_W-1:0]);
            agf_pkg::CSR_RAMP_SAMPLES:
               cfg_in.ramp_samples = csr_data[agf_pkg::RAMP_W-1:0];
            agf_pkg::CSR_EXP_STEP_LOG2:
               cfg_in.exp_step_log2 = csr_data[agf_pkg::EXP_STEP_W-1:0];
            default:
               cfg_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fade_mode     <= agf_pkg::MODE_LINEAR;
         cfg_ff.target_gain   <= agf_pkg::TARGET_RESET;
         cfg_ff.linear_step   <= '0;
         cfg_ff.ramp_samples  <= '0;
         cfg_ff.exp_step_log2 <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   agf_gain #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_gain (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .ramp_load       (cfg_hit),
      .ramp_load_value (cfg_in.ramp_samples),
      .advance         (req_accept),
      .gain_new        (gain_new)
   );

   agf_scale #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .in_gain    (gain_new),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (rsp_sample)
   );

   assign rsp_tdata = DATA_W'(rsp_sample);

endmodule
